### hdl/circular_list_table_macros.svh
// Assertion macros used by the list table RTL.
`ifndef CIRCULAR_LIST_TABLE_MACROS_SVH
`define CIRCULAR_LIST_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define CLT_ASSERT_NOW(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define CLT_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

### hdl/clt_pkg.sv
package clt_pkg;

	localparam int CAPACITY_DEF = 256;
	localparam int DATA_W       = 32;

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_REMOVE = 3'd1,
		OP_SEARCH = 3'd2,
		OP_PRED   = 3'd3,
		OP_SUCC   = 3'd4,
		OP_MIN    = 3'd5,
		OP_MAX    = 3'd6,
		OP_KTH    = 3'd7
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_BADPOS   = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_REMOVE,
		FSM_KCOUNT,
		FSM_KSKIP,
		FSM_RESTORE,
		FSM_FIN
	} fsm_t;

	typedef enum logic [1:0] {
		CM_HOLD,
		CM_INSERT,
		CM_REMOVE,
		CM_ROTATE
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t          mode;
		logic [DATA_W-1:0]   operand;
	} cell_cmd_t;

endpackage

### hdl/clt_cell.sv
module clt_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 9
) (
	input  logic                         clk,
	input  clt_pkg::cell_cmd_t           cmd,
	input  logic [CNT_W-1:0]             count,
	input  logic [CNT_W-1:0]             pos,
	input  logic [clt_pkg::DATA_W-1:0]   left,
	input  logic [clt_pkg::DATA_W-1:0]   right,
	input  logic [clt_pkg::DATA_W-1:0]   head,
	output logic [clt_pkg::DATA_W-1:0]   q
);

	localparam logic [CNT_W-1:0] IDXV = CNT_W'(IDX);
	localparam logic [CNT_W-1:0] NXTV = CNT_W'(IDX + 1);

	logic [clt_pkg::DATA_W-1:0] val_q;

	// Each cell picks from its left, its right, the head or the operand.
	always_ff @(posedge clk) begin
		case (cmd.mode)
			clt_pkg::CM_INSERT: begin
				if (count == '0) begin
					if (IDX == 0) val_q <= cmd.operand;
				end else if (IDX == 1) begin
					val_q <= cmd.operand;
				end else if (IDX > 1 && IDXV <= count) begin
					val_q <= left;
				end
			end
			clt_pkg::CM_REMOVE: begin
				if (IDXV >= pos && NXTV < count) val_q <= right;
			end
			clt_pkg::CM_ROTATE: begin
				if (NXTV < count) val_q <= right;
				else if (NXTV == count) val_q <= head;
			end
			default: begin
			end
		endcase
	end

	assign q = val_q;

endmodule

### hdl/circular_list_table.sv
// Insert and every error answer are given from idle; search, predecessor, successor,
// minimum and maximum walk the list once; remove walks it, then closes the gap.
// k-th largest: one full rotation per candidate, then the row is turned back.
// Throughput: one item at a time; the row of cells rotates by one entry per cycle.
// Reset (arst_n low): list empty, no result pending; entry values are not cleared.
`include "circular_list_table_macros.svh"

module circular_list_table #(
	parameter int CAPACITY = clt_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         opcode,
	input  logic signed [31:0] operand_value,
	input  logic [8:0]         position,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic signed [31:0] result_value,
	output logic [8:0]         entry_count
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int WW = (CW > 9) ? CW : 9;
	localparam logic [CW-1:0] CAP_V = CW'(CAPACITY);

	// Row of cells: cell 0 always holds the entry currently under the head.
	logic [clt_pkg::DATA_W-1:0] cell_val [CAPACITY];
	clt_pkg::cell_cmd_t cmd;
	logic [CW-1:0] cell_pos;

	clt_pkg::fsm_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	clt_pkg::opcode_t op_q, op_d;
	logic signed [31:0] operand_q, operand_d;
	logic [WW-1:0] pos_q, pos_d;
	logic [CW-1:0] step_q, step_d;
	logic [CW-1:0] rot_q, rot_d;
	logic hit_q, hit_d;
	logic signed [31:0] res_q, res_d;
	logic signed [31:0] cand_q, cand_d;
	logic [CW-1:0] gt_q, gt_d, ge_q, ge_d;
	clt_pkg::status_t st_q, st_d;

	logic out_valid_q, out_valid_d;
	clt_pkg::status_t out_st_q, out_st_d;
	logic signed [31:0] out_res_q, out_res_d;
	logic [CW-1:0] out_cnt_q, out_cnt_d;

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			clt_cell #(.IDX(g), .CNT_W(CW)) u_cell (
				.clk   (clk),
				.cmd   (cmd),
				.count (count_q),
				.pos   (cell_pos),
				.left  (cell_val[(g == 0) ? 0 : g - 1]),
				.right (cell_val[(g == CAPACITY - 1) ? g : g + 1]),
				.head  (cell_val[0]),
				.q     (cell_val[g])
			);
		end
	endgenerate

	assign cell_pos = pos_q[CW-1:0];

	logic in_xfer;
	assign in_stall = (state_q != clt_pkg::FSM_IDLE) || (out_valid_q && out_stall);
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= clt_pkg::FSM_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q      <= op_d;
		operand_q <= operand_d;
		pos_q     <= pos_d;
		step_q    <= step_d;
		rot_q     <= rot_d;
		hit_q     <= hit_d;
		res_q     <= res_d;
		cand_q    <= cand_d;
		gt_q      <= gt_d;
		ge_q      <= ge_d;
		st_q      <= st_d;
		out_st_q  <= out_st_d;
		out_res_q <= out_res_d;
		out_cnt_q <= out_cnt_d;
	end

	logic signed [31:0] cur, nxt, cand;
	logic [WW-1:0] cnt_w, in_pos_w;
	logic [CW-1:0] last, rot_n, gt_n, ge_n;
	logic out_free, scan_end, k_match;

	always_comb begin
		cur      = $signed(cell_val[0]);
		nxt      = (count_q == CW'(1)) ? $signed(cell_val[0]) : $signed(cell_val[1]);
		cnt_w    = WW'(count_q);
		in_pos_w = WW'(position);
		last     = count_q - CW'(1);
		rot_n    = (rot_q == last) ? '0 : rot_q + CW'(1);
		cand     = (step_q == '0) ? cur : cand_q;
		gt_n     = ((step_q == '0) ? '0 : gt_q) + CW'(cur > cand);
		ge_n     = ((step_q == '0) ? '0 : ge_q) + CW'(cur >= cand);
		k_match  = (WW'(gt_n) < pos_q) && (pos_q <= WW'(ge_n));
		scan_end = (step_q == last);
		out_free = !out_valid_q || !out_stall;

		state_d     = state_q;
		count_d     = count_q;
		op_d        = op_q;
		operand_d   = operand_q;
		pos_d       = pos_q;
		step_d      = step_q;
		rot_d       = rot_q;
		hit_d       = hit_q;
		res_d       = res_q;
		cand_d      = cand_q;
		gt_d        = gt_q;
		ge_d        = ge_q;
		st_d        = st_q;
		out_valid_d = out_valid_q && out_stall;
		out_st_d    = out_st_q;
		out_res_d   = out_res_q;
		out_cnt_d   = out_cnt_q;
		cmd.mode    = clt_pkg::CM_HOLD;
		cmd.operand = operand_value;

		case (state_q)
			clt_pkg::FSM_IDLE: begin
				if (in_xfer) begin
					op_d      = clt_pkg::opcode_t'(opcode);
					operand_d = operand_value;
					pos_d     = in_pos_w;
					step_d    = '0;
					rot_d     = '0;
					hit_d     = 1'b0;
					res_d     = '0;
					st_d      = clt_pkg::ST_OK;
					out_res_d = '0;
					out_cnt_d = count_q;
					if (clt_pkg::opcode_t'(opcode) == clt_pkg::OP_INSERT) begin
						out_valid_d = 1'b1;
						if (count_q == CAP_V) begin
							out_st_d = clt_pkg::ST_FULL;
						end else begin
							cmd.mode  = clt_pkg::CM_INSERT;
							count_d   = count_q + CW'(1);
							out_cnt_d = count_q + CW'(1);
							out_st_d  = clt_pkg::ST_OK;
						end
					end else if (count_q == '0) begin
						out_valid_d = 1'b1;
						out_st_d    = clt_pkg::ST_EMPTY;
					end else if (clt_pkg::opcode_t'(opcode) == clt_pkg::OP_REMOVE &&
						in_pos_w >= cnt_w) begin
						out_valid_d = 1'b1;
						out_st_d    = clt_pkg::ST_BADPOS;
					end else if (clt_pkg::opcode_t'(opcode) == clt_pkg::OP_KTH) begin
						if (in_pos_w == '0 || in_pos_w > cnt_w) begin
							out_valid_d = 1'b1;
							out_st_d    = clt_pkg::ST_BADPOS;
						end else begin
							state_d = clt_pkg::FSM_KCOUNT;
						end
					end else begin
						state_d = clt_pkg::FSM_SCAN;
					end
				end
			end
			clt_pkg::FSM_SCAN: begin
				// Walk the whole circle once so the row ends where it began.
				cmd.mode = clt_pkg::CM_ROTATE;
				step_d   = step_q + CW'(1);
				case (op_q)
					clt_pkg::OP_REMOVE: begin
						if (WW'(step_q) == pos_q) res_d = cur;
					end
					clt_pkg::OP_SEARCH: begin
						if (!hit_q && cur == operand_q) hit_d = 1'b1;
					end
					clt_pkg::OP_SUCC: begin
						if (!hit_q && cur == operand_q) begin
							hit_d = 1'b1;
							res_d = nxt;
						end
					end
					clt_pkg::OP_PRED: begin
						if (!hit_q && nxt == operand_q) begin
							hit_d = 1'b1;
							res_d = cur;
						end
					end
					clt_pkg::OP_MIN: begin
						if (step_q == '0 || cur < res_q) res_d = cur;
					end
					clt_pkg::OP_MAX: begin
						if (step_q == '0 || cur > res_q) res_d = cur;
					end
					default: begin
					end
				endcase
				if (scan_end) begin
					if ((op_q == clt_pkg::OP_SEARCH || op_q == clt_pkg::OP_PRED ||
						op_q == clt_pkg::OP_SUCC) && !hit_d) begin
						st_d = clt_pkg::ST_NOTFOUND;
					end
					state_d = (op_q == clt_pkg::OP_REMOVE) ? clt_pkg::FSM_REMOVE
						: clt_pkg::FSM_FIN;
				end
			end
			clt_pkg::FSM_REMOVE: begin
				// Close the gap: cells from the position onward take their right neighbour.
				cmd.mode = clt_pkg::CM_REMOVE;
				count_d  = count_q - CW'(1);
				state_d  = clt_pkg::FSM_FIN;
			end
			clt_pkg::FSM_KCOUNT: begin
				cmd.mode = clt_pkg::CM_ROTATE;
				rot_d    = rot_n;
				cand_d   = cand;
				gt_d     = gt_n;
				ge_d     = ge_n;
				step_d   = step_q + CW'(1);
				if (scan_end) begin
					step_d = '0;
					if (k_match) begin
						res_d   = cand;
						state_d = (rot_n == '0) ? clt_pkg::FSM_FIN : clt_pkg::FSM_RESTORE;
					end else begin
						state_d = clt_pkg::FSM_KSKIP;
					end
				end
			end
			clt_pkg::FSM_KSKIP: begin
				// Advance one entry so the next pass opens on a new candidate.
				cmd.mode = clt_pkg::CM_ROTATE;
				rot_d    = rot_n;
				state_d  = clt_pkg::FSM_KCOUNT;
			end
			clt_pkg::FSM_RESTORE: begin
				cmd.mode = clt_pkg::CM_ROTATE;
				rot_d    = rot_n;
				if (rot_n == '0) state_d = clt_pkg::FSM_FIN;
			end
			clt_pkg::FSM_FIN: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					out_st_d    = st_q;
					out_res_d   = res_q;
					out_cnt_d   = count_q;
					state_d     = clt_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = clt_pkg::FSM_IDLE;
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign status       = out_st_q;
	assign result_value = out_res_q;
	assign entry_count  = 9'(out_cnt_q);

	`CLT_ASSERT_NEXT(a_accept_busy, in_xfer, state_q != clt_pkg::FSM_IDLE || out_valid_q, "transfer accepted but neither busy nor answering")
	`CLT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CAP_V, "entry count above capacity")
	`CLT_ASSERT_NOW(a_busy_stall, state_q != clt_pkg::FSM_IDLE, in_stall, "input not stalled while busy")
	`CLT_ASSERT_NOW(a_walk_nonempty, state_q == clt_pkg::FSM_SCAN || state_q == clt_pkg::FSM_RESTORE || state_q == clt_pkg::FSM_KCOUNT, count_q != '0, "rotation on an empty list")

endmodule
